// ===== rtl/rrua_pkg.sv =====
package rrua_pkg;

   // Sizing of the unit pool.
   localparam int MAX_UNITS = 8;
   localparam int UNIT_W    = $clog2(MAX_UNITS);
   localparam int COUNT_W   = 4;
   localparam int CLASS_W   = 2;

   // Operation codes.
   localparam logic FUNC_ACQUIRE = 1'b0;
   localparam logic FUNC_RELEASE = 1'b1;

   // Requester classes.
   localparam logic [CLASS_W-1:0] CLASS_NONE   = 2'd0;
   localparam logic [CLASS_W-1:0] CLASS_STREAM = 2'd1;
   localparam logic [CLASS_W-1:0] CLASS_SCAN   = 2'd2;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_SEARCH,
      ST_COMMIT
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic reduce;
      logic search;
      logic commit;
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic slot_free;
   } dp_status_type;

endpackage

// ===== rtl/rrua_req_if.sv =====
interface rrua_req_if;
   logic                       valid;
   logic                       ready;
   logic                       func;
   logic [rrua_pkg::CLASS_W-1:0] purpose;
   logic [rrua_pkg::UNIT_W-1:0]  unit_index;

   modport source (output valid, func, purpose, unit_index, input ready);
   modport sink   (input valid, func, purpose, unit_index, output ready);
endinterface

// ===== rtl/rrua_rsp_if.sv =====
interface rrua_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      granted;
   logic [rrua_pkg::UNIT_W-1:0] result_unit;
   logic                      preempted;

   modport source (output valid, granted, result_unit, preempted, input ready);
   modport sink   (input valid, granted, result_unit, preempted, output ready);
endinterface

// ===== rtl/rrua_ctrl.sv =====
module rrua_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  rrua_pkg::dp_status_type status,
   output rrua_pkg::ctrl_cmd_type  cmd
);

   rrua_pkg::state_type state_ff;
   rrua_pkg::state_type state_in;

   // Next state: one transaction walks through reduce, search and commit.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rrua_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = rrua_pkg::ST_REDUCE;
            end
         end
         rrua_pkg::ST_REDUCE: begin
            state_in = rrua_pkg::ST_SEARCH;
         end
         rrua_pkg::ST_SEARCH: begin
            state_in = rrua_pkg::ST_COMMIT;
         end
         rrua_pkg::ST_COMMIT: begin
            if (status.slot_free) begin
               state_in = rrua_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rrua_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs decoded from the current state.
   always_comb begin
      req_ready  = 1'b0;
      cmd        = '0;
      case (state_ff)
         rrua_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         rrua_pkg::ST_REDUCE: begin
            cmd.reduce = 1'b1;
         end
         rrua_pkg::ST_SEARCH: begin
            cmd.search = 1'b1;
         end
         rrua_pkg::ST_COMMIT: begin
            cmd.commit = status.slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rrua_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/rrua_datapath.sv =====
module rrua_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  rrua_pkg::ctrl_cmd_type        cmd,
   output rrua_pkg::dp_status_type       status,
   input  logic                          csr_wr_en,
   input  logic [rrua_pkg::COUNT_W-1:0]  csr_wr_data,
   input  logic                          req_func,
   input  logic [rrua_pkg::CLASS_W-1:0]  req_purpose,
   input  logic [rrua_pkg::UNIT_W-1:0]   req_unit_index,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic                          rsp_granted,
   output logic [rrua_pkg::UNIT_W-1:0]   rsp_result_unit,
   output logic                          rsp_preempted
);

   localparam int N = rrua_pkg::MAX_UNITS;
   localparam int UW = rrua_pkg::UNIT_W;
   localparam int CW = rrua_pkg::COUNT_W;
   localparam int KW = rrua_pkg::CLASS_W;

   // Reduce a start index modulo the live count by repeated subtraction.
   function automatic logic [UW-1:0] reduce_mod(input logic [UW-1:0] v,
                                                input logic [CW-1:0] n);
      logic [CW-1:0] r;
      r = CW'(v);
      for (int k = 0; k < N; k++) begin
         if (n != '0 && r >= n) begin
            r = r - n;
         end
      end
      return UW'(r);
   endfunction

   // Rotating priority pick: first candidate at or after start, else first overall.
   function automatic logic [UW:0] rr_pick(input logic [N-1:0] cand,
                                           input logic [UW-1:0] start);
      logic          hi_hit;
      logic          lo_hit;
      logic [UW-1:0] hi_idx;
      logic [UW-1:0] lo_idx;
      hi_hit = 1'b0;
      lo_hit = 1'b0;
      hi_idx = '0;
      lo_idx = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (cand[i]) begin
            lo_hit = 1'b1;
            lo_idx = UW'(i);
            if (UW'(i) >= start) begin
               hi_hit = 1'b1;
               hi_idx = UW'(i);
            end
         end
      end
      return hi_hit ? {1'b1, hi_idx} : {lo_hit, lo_idx};
   endfunction

   // Architectural state.
   logic [CW-1:0] unit_count_ff;
   logic [N-1:0]  busy_ff, busy_in;
   logic [KW-1:0] class_ff [N];
   logic [KW-1:0] class_in [N];
   logic [UW-1:0] search_start_ff, search_start_in;

   // Captured transaction and intermediate results.
   logic          func_ff;
   logic [KW-1:0] purpose_ff;
   logic [UW-1:0] index_ff;
   logic [UW-1:0] start_ff;
   logic          free_found_ff;
   logic [UW-1:0] free_idx_ff;
   logic          scan_found_ff;
   logic [UW-1:0] scan_idx_ff;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          granted_ff;
   logic [UW-1:0] result_unit_ff;
   logic          preempted_ff;

   logic [CW-1:0] live_n;
   logic [N-1:0]  free_cand;
   logic [N-1:0]  scan_cand;
   logic [UW:0]   free_pick;
   logic [UW:0]   scan_pick;

   logic          ok;
   logic          pre;
   logic [UW-1:0] unit;
   logic [CW-1:0] unit_next;

   // A count above the pool size behaves as the pool size.
   assign live_n = (unit_count_ff > CW'(N)) ? CW'(N) : unit_count_ff;

   // Candidate vectors over the live units.
   always_comb begin
      for (int i = 0; i < N; i++) begin
         free_cand[i] = !busy_ff[i] && (CW'(i) < live_n);
         scan_cand[i] = (class_ff[i] == rrua_pkg::CLASS_SCAN) && (CW'(i) < live_n);
      end
   end

   assign free_pick = rr_pick(free_cand, start_ff);
   assign scan_pick = rr_pick(scan_cand, start_ff);

   // Outcome of the transaction, used in the commit cycle.
   always_comb begin
      ok   = 1'b0;
      pre  = 1'b0;
      unit = '0;
      if (func_ff == rrua_pkg::FUNC_ACQUIRE) begin
         if (free_found_ff) begin
            ok   = 1'b1;
            unit = free_idx_ff;
         end else if (purpose_ff == rrua_pkg::CLASS_STREAM && scan_found_ff) begin
            ok   = 1'b1;
            pre  = 1'b1;
            unit = scan_idx_ff;
         end
      end else if (CW'(index_ff) < live_n) begin
         ok   = 1'b1;
         unit = index_ff;
      end
   end

   assign unit_next = CW'(unit) + CW'(1);

   // State updates applied at commit.
   always_comb begin
      busy_in         = busy_ff;
      class_in        = class_ff;
      search_start_in = search_start_ff;
      if (cmd.commit && ok) begin
         if (func_ff == rrua_pkg::FUNC_ACQUIRE) begin
            busy_in[unit]   = 1'b1;
            class_in[unit]  = pre ? rrua_pkg::CLASS_STREAM : purpose_ff;
            search_start_in = (unit_next == live_n) ? '0 : UW'(unit_next);
         end else begin
            busy_in[unit]  = 1'b0;
            class_in[unit] = rrua_pkg::CLASS_NONE;
         end
      end
   end

   // The result slot frees when empty or when its transaction is taken.
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control and architectural registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         unit_count_ff   <= '0;
         busy_ff         <= '0;
         search_start_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int i = 0; i < N; i++) begin
            class_ff[i] <= rrua_pkg::CLASS_NONE;
         end
      end else begin
         if (csr_wr_en) begin
            unit_count_ff <= csr_wr_data;
         end
         busy_ff         <= busy_in;
         class_ff        <= class_in;
         search_start_ff <= search_start_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // Payload registers along the transaction path.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff    <= req_func;
         purpose_ff <= req_purpose;
         index_ff   <= req_unit_index;
      end
      if (cmd.reduce) begin
         start_ff <= reduce_mod(search_start_ff, live_n);
      end
      if (cmd.search) begin
         free_found_ff <= free_pick[UW];
         free_idx_ff   <= free_pick[UW-1:0];
         scan_found_ff <= scan_pick[UW];
         scan_idx_ff   <= scan_pick[UW-1:0];
      end
      if (cmd.commit) begin
         granted_ff     <= ok;
         result_unit_ff <= unit;
         preempted_ff   <= pre;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_result_unit = result_unit_ff;
   assign rsp_preempted   = preempted_ff;

endmodule

// ===== rtl/round_robin_unit_allocator.sv =====
// Channel   Direction  Handshake      Payload
// req_chan  in         valid/ready    func, purpose, unit_index
// rsp_chan  out        valid/ready    granted, result_unit, preempted
// csr       in         csr_wr_en      csr_wr_data (unit_count)
//
// Each transaction goes through these steps from acceptance to a loaded result register:
// accept, reduce the search start modulo the unit count, rotating priority search,
// commit. The controller walks one transaction at a time through these steps.
// A waiting result does not block acceptance; commit waits only while the result
// register is still full. Reset is synchronous and empties every unit.
module round_robin_unit_allocator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_wr_en,
   input  logic [rrua_pkg::COUNT_W-1:0] csr_wr_data,
   rrua_req_if.sink                     req_chan,
   rrua_rsp_if.source                   rsp_chan
);

   rrua_pkg::ctrl_cmd_type  cmd;
   rrua_pkg::dp_status_type status;

   // Sequencer.
   rrua_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Unit state, search and result register.
   rrua_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .req_func        (req_chan.func),
      .req_purpose     (req_chan.purpose),
      .req_unit_index  (req_chan.unit_index),
      .rsp_ready       (rsp_chan.ready),
      .rsp_valid       (rsp_chan.valid),
      .rsp_granted     (rsp_chan.granted),
      .rsp_result_unit (rsp_chan.result_unit),
      .rsp_preempted   (rsp_chan.preempted)
   );

endmodule

// ===== rtl/rrua_checker.sv =====
module rrua_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_granted,
   input logic [rrua_pkg::UNIT_W-1:0] rsp_result_unit,
   input logic                        rsp_preempted
);

   logic req_fire;
   assign req_fire = req_valid && req_ready;

   // A pending result transaction stays offered until taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // One transaction at a time: no acceptance in the cycle after an acceptance.
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_fire)
      else $error("request accepted on consecutive cycles");

   // A fresh result must match a request accepted ahead of the reduce, search and commit steps.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_fire, 4))
      else $error("result appeared without a matching request");

   // A failed operation reports unit zero and no preemption.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_granted |-> rsp_result_unit == '0 && !rsp_preempted)
      else $error("failed operation carries nonzero fields");

endmodule

bind round_robin_unit_allocator rrua_checker u_rrua_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_granted     (rsp_chan.granted),
   .rsp_result_unit (rsp_chan.result_unit),
   .rsp_preempted   (rsp_chan.preempted)
);
